FILE: design/ced_pkg.sv
// Shared constants and types for the Canny edge detector.
package ced_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W     = 8;
  localparam int MAG_W     = 10;
  localparam int SUP_W     = 8;
  localparam int ROW_W     = 14;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 10;

  localparam logic [PIX_W-1:0]   HIGH_RST  = 8'd220;
  localparam logic [PIX_W-1:0]   LOW_RST   = 8'd135;
  localparam logic [IMG_W_W-1:0] WIDTH_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [PIX_W-1:0]   EDGE_ON   = 8'd255;
  localparam logic [PIX_W-1:0]   EDGE_OFF  = 8'd0;

  // tan(22.5) and tan(67.5) in 8-bit fraction fixed point
  localparam int TAN22 = 106;
  localparam int TAN67 = 618;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH   = 2'd0,
    REG_LOW    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEC_HORZ = 2'd0,
    SEC_DIAG = 2'd1,
    SEC_VERT = 2'd2,
    SEC_ANTI = 2'd3
  } sector_t;

endpackage

FILE: design/ced_ram.sv
// Generic simple dual-port RAM with registered read.
module ced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/canny_edge_detector.sv
// Canny edge detector top level: Sobel, non-maximum suppression, hysteresis.
// Takes one pixel word per clock in raster order and returns one edge word per
// pixel (0 or 255, with its row, column and a frame-end flag), one per clock.
// Three 3x3 stages (gradient, suppression, hysteresis) each hold two rows in a
// line RAM, one entry per column, read ahead into a registered output and
// written back as the window shifts. The edge word for frame position q comes
// with the stream word 3*W+3 positions after pixel q, once through the pipeline.
// After the last pixel of a frame, send 3*W+3 words with flush set (or any
// words) to drain it; flush words inside a frame are taken and dropped.
// Border pixels give 0. Writing width or height restarts the frame;
// thresholds take effect at once. Only a stalled output holds the pipeline.
module canny_edge_detector #(
  parameter int MAX_WIDTH  = ced_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ced_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ced_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           in_flush,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ced_pkg::PIX_W-1:0]      out_edge_res,
  output logic [ced_pkg::OUT_ROW_W-1:0]  out_row,
  output logic [ced_pkg::OUT_COL_W-1:0]  out_col,
  output logic                           out_frame_last,
  input  logic                           cfg_we,
  input  logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ced_pkg::CFG_W-1:0]      cfg_data
);
  import ced_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int PW = ROW_W + CW;

  typedef struct packed {
    logic                 do1;
    logic                 do2;
    logic                 do3;
    logic [CW-1:0]        x0;
    logic [CW-1:0]        x1;
    logic [CW-1:0]        x2;
    logic                 int1;
    logic                 int2;
    logic                 int3;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } item_t;

  // configuration
  logic [PIX_W-1:0]   high_r, low_r;
  logic [IMG_W_W-1:0] wid_r;
  logic [IMG_H_W-1:0] hgt_r;
  logic [IMG_W_W-1:0] wid_clamp;
  logic [IMG_H_W-1:0] hgt_clamp;
  logic               geo_wr;

  // stream position of each stage
  logic [ROW_W-1:0] s_row_r, a_row_r, b_row_r, c_row_r;
  logic [ROW_W-1:0] s_row_nxt, a_row_nxt, b_row_nxt, c_row_nxt;
  logic [CW-1:0]    s_col_r, a_col_r, b_col_r, c_col_r;
  logic [CW-1:0]    s_col_nxt, a_col_nxt, b_col_nxt, c_col_nxt;
  logic             act1_r, act2_r, act3_r, drain_r;
  logic             act1_nxt, act2_nxt, act3_nxt, drain_nxt;

  logic  en, take, do1, do2, do3;
  item_t itm_new;

  logic [7:1]       vld_r;
  item_t            itm_r [1:7];
  logic [PIX_W-1:0] pix1_r;
  logic signed [10:0] gx3_r, gy3_r;
  logic [MAG_W-1:0] mag4_r;
  logic [SUP_W-1:0] sup6_r;

  logic [PIX_W-1:0] pwin_r [9];
  logic [MAG_W-1:0] mwin_r [9];
  logic [SUP_W-1:0] swin_r [9];

  logic [2*PIX_W-1:0] prd;
  logic [2*MAG_W-1:0] mrd;
  logic [2*SUP_W-1:0] srd;

  logic             out_vld_r;
  logic [PIX_W-1:0] out_edge_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic             out_last_r;

  function automatic logic col_end(logic [CW-1:0] c, logic [IMG_W_W-1:0] w);
    return XW'(c) == XW'(w) - XW'(1);
  endfunction

  function automatic logic row_end(logic [ROW_W-1:0] r, logic [IMG_H_W-1:0] h);
    return r == ROW_W'(h) - ROW_W'(1);
  endfunction

  function automatic logic at_one(logic [ROW_W-1:0] r, logic [CW-1:0] c);
    return (r == ROW_W'(1)) && (c == CW'(1));
  endfunction

  function automatic logic inner(logic [ROW_W-1:0] r, logic [CW-1:0] c,
                                 logic [IMG_W_W-1:0] w, logic [IMG_H_W-1:0] h);
    return (r != '0) && (r <= ROW_W'(h) - ROW_W'(2)) &&
           (c != '0) && (XW'(c) <= XW'(w) - XW'(2));
  endfunction

  function automatic logic [PW-1:0] step_pos(logic [ROW_W-1:0] r, logic [CW-1:0] c,
                                             logic [IMG_W_W-1:0] w);
    logic [PW-1:0] res;
    if (col_end(c, w)) begin
      res = {r + ROW_W'(1), CW'(0)};
    end else begin
      res = {r, c + CW'(1)};
    end
    return res;
  endfunction

  // ---------------- configuration ----------------
  always_comb begin
    if (cfg_data[IMG_W_W-1:0] < IMG_W_W'(3)) begin
      wid_clamp = IMG_W_W'(3);
    end else if (int'(cfg_data[IMG_W_W-1:0]) > MAX_WIDTH) begin
      wid_clamp = IMG_W_W'(MAX_WIDTH);
    end else begin
      wid_clamp = cfg_data[IMG_W_W-1:0];
    end
    if (cfg_data[IMG_H_W-1:0] < IMG_H_W'(3)) begin
      hgt_clamp = IMG_H_W'(3);
    end else if (int'(cfg_data[IMG_H_W-1:0]) > MAX_HEIGHT) begin
      hgt_clamp = IMG_H_W'(MAX_HEIGHT);
    end else begin
      hgt_clamp = cfg_data[IMG_H_W-1:0];
    end
  end

  assign geo_wr = cfg_we && ((cfg_reg_t'(cfg_index) == REG_WIDTH) ||
                             (cfg_reg_t'(cfg_index) == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_RST;
      low_r  <= LOW_RST;
      wid_r  <= WIDTH_RST;
      hgt_r  <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HIGH:   high_r <= cfg_data[PIX_W-1:0];
        REG_LOW:    low_r  <= cfg_data[PIX_W-1:0];
        REG_WIDTH:  wid_r  <= wid_clamp;
        REG_HEIGHT: hgt_r  <= hgt_clamp;
        default:    high_r <= high_r;
      endcase
    end
  end

  // ---------------- input side position tracking ----------------
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;
  assign take     = in_valid && en && (drain_r || !in_flush);

  assign do1 = act1_r || at_one(s_row_r, s_col_r);
  assign do2 = do1 && (act2_r || at_one(a_row_r, a_col_r));
  assign do3 = do2 && (act3_r || at_one(b_row_r, b_col_r));

  always_comb begin
    itm_new.do1  = do1;
    itm_new.do2  = do2;
    itm_new.do3  = do3;
    itm_new.x0   = s_col_r;
    itm_new.x1   = a_col_r;
    itm_new.x2   = b_col_r;
    itm_new.int1 = inner(a_row_r, a_col_r, wid_r, hgt_r);
    itm_new.int2 = inner(b_row_r, b_col_r, wid_r, hgt_r);
    itm_new.int3 = inner(c_row_r, c_col_r, wid_r, hgt_r);
    itm_new.row  = OUT_ROW_W'(c_row_r);
    itm_new.col  = OUT_COL_W'(c_col_r);
    itm_new.last = row_end(c_row_r, hgt_r) && col_end(c_col_r, wid_r);
  end

  always_comb begin
    s_row_nxt = s_row_r;  s_col_nxt = s_col_r;
    a_row_nxt = a_row_r;  a_col_nxt = a_col_r;
    b_row_nxt = b_row_r;  b_col_nxt = b_col_r;
    c_row_nxt = c_row_r;  c_col_nxt = c_col_r;
    act1_nxt  = act1_r;   act2_nxt  = act2_r;
    act3_nxt  = act3_r;   drain_nxt = drain_r;
    if (take) begin
      {s_row_nxt, s_col_nxt} = step_pos(s_row_r, s_col_r, wid_r);
      if (!drain_r && row_end(s_row_r, hgt_r) && col_end(s_col_r, wid_r)) begin
        drain_nxt = 1'b1;
      end
      if (do1) begin
        {a_row_nxt, a_col_nxt} = step_pos(a_row_r, a_col_r, wid_r);
        act1_nxt = 1'b1;
      end
      if (do2) begin
        {b_row_nxt, b_col_nxt} = step_pos(b_row_r, b_col_r, wid_r);
        act2_nxt = 1'b1;
      end
      if (do3) begin
        {c_row_nxt, c_col_nxt} = step_pos(c_row_r, c_col_r, wid_r);
        act3_nxt = 1'b1;
      end
    end
    // frame end drained, or geometry changed: start over at pixel (0,0)
    if ((take && do3 && itm_new.last) || geo_wr) begin
      s_row_nxt = '0;  s_col_nxt = '0;
      a_row_nxt = '0;  a_col_nxt = '0;
      b_row_nxt = '0;  b_col_nxt = '0;
      c_row_nxt = '0;  c_col_nxt = '0;
      act1_nxt  = 1'b0;  act2_nxt = 1'b0;
      act3_nxt  = 1'b0;  drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_row_r <= '0;  s_col_r <= '0;
      a_row_r <= '0;  a_col_r <= '0;
      b_row_r <= '0;  b_col_r <= '0;
      c_row_r <= '0;  c_col_r <= '0;
      act1_r  <= 1'b0;  act2_r <= 1'b0;
      act3_r  <= 1'b0;  drain_r <= 1'b0;
    end else begin
      s_row_r <= s_row_nxt;  s_col_r <= s_col_nxt;
      a_row_r <= a_row_nxt;  a_col_r <= a_col_nxt;
      b_row_r <= b_row_nxt;  b_col_r <= b_col_nxt;
      c_row_r <= c_row_nxt;  c_col_r <= c_col_nxt;
      act1_r  <= act1_nxt;   act2_r  <= act2_nxt;
      act3_r  <= act3_nxt;   drain_r <= drain_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_r[1] <= itm_new;
      for (int k = 2; k <= 7; k++) begin
        itm_r[k] <= itm_r[k-1];
      end
      pix1_r <= drain_r ? '0 : in_pixel;
    end
  end

  // ---------------- stage 1: pixel lines and window ----------------
  // line entry holds {row y-2, row y-1} for one column
  ced_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_pix_ram (
    .clk   (clk),
    .we    (en && vld_r[1]),
    .waddr (itm_r[1].x0),
    .wdata ({prd[PIX_W-1:0], pix1_r}),
    .re    (take),
    .raddr (s_col_r),
    .rdata (prd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        pwin_r[i] <= '0;
      end
    end else if (en && vld_r[1]) begin
      for (int r = 0; r < 3; r++) begin
        pwin_r[r*3]   <= pwin_r[r*3+1];
        pwin_r[r*3+1] <= pwin_r[r*3+2];
      end
      pwin_r[2] <= prd[2*PIX_W-1:PIX_W];
      pwin_r[5] <= prd[PIX_W-1:0];
      pwin_r[8] <= pix1_r;
    end
  end

  // ---------------- stage 2: Sobel sums ----------------
  logic [9:0] sum_r, sum_l, sum_d, sum_u;

  always_comb begin
    sum_r = 10'(pwin_r[2]) + {1'b0, pwin_r[5], 1'b0} + 10'(pwin_r[8]);
    sum_l = 10'(pwin_r[0]) + {1'b0, pwin_r[3], 1'b0} + 10'(pwin_r[6]);
    sum_d = 10'(pwin_r[6]) + {1'b0, pwin_r[7], 1'b0} + 10'(pwin_r[8]);
    sum_u = 10'(pwin_r[0]) + {1'b0, pwin_r[1], 1'b0} + 10'(pwin_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx3_r <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      gy3_r <= $signed({1'b0, sum_d}) - $signed({1'b0, sum_u});
    end
  end

  // ---------------- stage 3: magnitude and sector ----------------
  logic [10:0]      gx_abs, gy_abs;
  logic [9:0]       ax, ay;
  logic [10:0]      mag_sum;
  logic [PIX_W-1:0] mag_sat;
  logic [19:0]      ay_sc, ax_lo, ax_hi;
  logic             gx_pos, gy_pos;
  sector_t          sec;

  always_comb begin
    gx_abs  = gx3_r[10] ? 11'(-gx3_r) : gx3_r;
    gy_abs  = gy3_r[10] ? 11'(-gy3_r) : gy3_r;
    ax      = gx_abs[9:0];
    ay      = gy_abs[9:0];
    mag_sum = 11'(ax) + 11'(ay);
    mag_sat = (mag_sum > 11'd255) ? 8'd255 : mag_sum[7:0];
    ay_sc   = {2'b00, ay, 8'b0};
    ax_lo   = 20'(ax) * 20'(TAN22);
    ax_hi   = 20'(ax) * 20'(TAN67);
    gx_pos  = !gx3_r[10] && (gx3_r != '0);
    gy_pos  = !gy3_r[10] && (gy3_r != '0);
    priority if (ay_sc <= ax_lo) begin
      sec = SEC_HORZ;
    end else if (ay_sc > ax_hi) begin
      sec = SEC_VERT;
    end else if (gx_pos == gy_pos) begin
      sec = SEC_DIAG;
    end else begin
      sec = SEC_ANTI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r <= itm_r[3].int1 ? {sec, mag_sat} : '0;
    end
  end

  // ---------------- stage 4: magnitude lines and window ----------------
  ced_ram #(.WIDTH(2*MAG_W), .DEPTH(MAX_WIDTH)) u_mag_ram (
    .clk   (clk),
    .we    (en && vld_r[4] && itm_r[4].do1),
    .waddr (itm_r[4].x1),
    .wdata ({mrd[MAG_W-1:0], mag4_r}),
    .re    (en && vld_r[3] && itm_r[3].do1),
    .raddr (itm_r[3].x1),
    .rdata (mrd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        mwin_r[i] <= '0;
      end
    end else if (en && vld_r[4] && itm_r[4].do1) begin
      for (int r = 0; r < 3; r++) begin
        mwin_r[r*3]   <= mwin_r[r*3+1];
        mwin_r[r*3+1] <= mwin_r[r*3+2];
      end
      mwin_r[2] <= mrd[2*MAG_W-1:MAG_W];
      mwin_r[5] <= mrd[MAG_W-1:0];
      mwin_r[8] <= mag4_r;
    end
  end

  // ---------------- stage 5: non-maximum suppression ----------------
  logic [PIX_W-1:0] m_ctr, n1, n2, sup_val;

  always_comb begin
    m_ctr = mwin_r[4][PIX_W-1:0];
    unique case (sector_t'(mwin_r[4][MAG_W-1:PIX_W]))
      SEC_HORZ: begin n1 = mwin_r[3][PIX_W-1:0]; n2 = mwin_r[5][PIX_W-1:0]; end
      SEC_VERT: begin n1 = mwin_r[1][PIX_W-1:0]; n2 = mwin_r[7][PIX_W-1:0]; end
      SEC_DIAG: begin n1 = mwin_r[0][PIX_W-1:0]; n2 = mwin_r[8][PIX_W-1:0]; end
      SEC_ANTI: begin n1 = mwin_r[2][PIX_W-1:0]; n2 = mwin_r[6][PIX_W-1:0]; end
      default:  begin n1 = '0; n2 = '0; end
    endcase
    sup_val = ((m_ctr < n1) || (m_ctr < n2)) ? '0 : m_ctr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sup6_r <= itm_r[5].int2 ? sup_val : '0;
    end
  end

  // ---------------- stage 6: suppressed lines and window ----------------
  ced_ram #(.WIDTH(2*SUP_W), .DEPTH(MAX_WIDTH)) u_sup_ram (
    .clk   (clk),
    .we    (en && vld_r[6] && itm_r[6].do2),
    .waddr (itm_r[6].x2),
    .wdata ({srd[SUP_W-1:0], sup6_r}),
    .re    (en && vld_r[5] && itm_r[5].do2),
    .raddr (itm_r[5].x2),
    .rdata (srd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        swin_r[i] <= '0;
      end
    end else if (en && vld_r[6] && itm_r[6].do2) begin
      for (int r = 0; r < 3; r++) begin
        swin_r[r*3]   <= swin_r[r*3+1];
        swin_r[r*3+1] <= swin_r[r*3+2];
      end
      swin_r[2] <= srd[2*SUP_W-1:SUP_W];
      swin_r[5] <= srd[SUP_W-1:0];
      swin_r[8] <= sup6_r;
    end
  end

  // ---------------- stage 7: hysteresis and output word ----------------
  logic [8:0]       over_hi;
  logic [PIX_W-1:0] hys_val;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      over_hi[i] = swin_r[i] > high_r;
    end
    priority if (!itm_r[7].int3) begin
      hys_val = EDGE_OFF;
    end else if (swin_r[4] < low_r) begin
      hys_val = EDGE_OFF;
    end else if (swin_r[4] > high_r) begin
      hys_val = EDGE_ON;
    end else if (over_hi != '0) begin
      hys_val = EDGE_ON;
    end else begin
      hys_val = EDGE_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[7] && itm_r[7].do3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_edge_r <= hys_val;
      out_row_r  <= itm_r[7].row;
      out_col_r  <= itm_r[7].col;
      out_last_r <= itm_r[7].last;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_edge_res   = out_edge_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

  // ---------------- assertions ----------------
  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    act3_r |-> (act2_r && act1_r))
    else $error("later stage active before earlier one");

  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_edge_res == EDGE_OFF || out_edge_res == EDGE_ON))
    else $error("edge word not 0 or 255");

  a_drain_pos: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (s_row_r >= ROW_W'(hgt_r)))
    else $error("drain flagged inside the frame");

endmodule

FILE: verif/canny_edge_checker.sv
// Edge stream checker: predicts each edge word from the accepted pixel words and compares.
module canny_edge_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ced_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_flush,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ced_pkg::PIX_W-1:0]     out_edge_res,
  input  logic [ced_pkg::OUT_ROW_W-1:0] out_row,
  input  logic [ced_pkg::OUT_COL_W-1:0] out_col,
  input  logic                          out_frame_last,
  input  logic                          cfg_we,
  input  logic [ced_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ced_pkg::CFG_W-1:0]     cfg_data,
  output int                            fails,
  output int                            pending
);
  import ced_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]     edge_v;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } edge_word_t;

  edge_word_t edge_q[$];

  // stage 0: pixels, 1: magnitudes {sector, mag}, 2: thinned magnitudes
  bit [9:0] line_mem [3][2*MAX_WIDTH_DEF];
  bit [9:0] win [3][9];

  int unsigned hi_thr, lo_thr, img_w, img_h;
  int unsigned pix_row, pix_col, drain_cnt;
  bit          draining;

  assign pending = edge_q.size();

  function automatic void shift_in(int st, int unsigned pos, bit [9:0] v);
    int unsigned y, x, old_s, mid_s;
    bit [9:0] top, mid;
    y = pos / img_w;
    x = pos % img_w;
    old_s = (y & 1) * MAX_WIDTH_DEF + x;
    mid_s = ((y + 1) & 1) * MAX_WIDTH_DEF + x;
    top = line_mem[st][old_s];
    mid = line_mem[st][mid_s];
    for (int r = 0; r < 3; r++) begin
      win[st][r*3]   = win[st][r*3+1];
      win[st][r*3+1] = win[st][r*3+2];
    end
    win[st][2] = top;
    win[st][5] = mid;
    win[st][8] = v;
    line_mem[st][old_s] = v;
  endfunction

  function automatic bit is_interior(int unsigned pos);
    int unsigned r, c;
    r = pos / img_w;
    c = pos % img_w;
    return r >= 1 && r + 2 <= img_h && c >= 1 && c + 2 <= img_w;
  endfunction

  function automatic bit [9:0] sobel();
    int gx, gy, ax, ay, mag;
    sector_t sec;
    gx = (int'(win[0][2]) + 2*int'(win[0][5]) + int'(win[0][8]))
       - (int'(win[0][0]) + 2*int'(win[0][3]) + int'(win[0][6]));
    gy = (int'(win[0][6]) + 2*int'(win[0][7]) + int'(win[0][8]))
       - (int'(win[0][0]) + 2*int'(win[0][1]) + int'(win[0][2]));
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    mag = ax + ay;
    if (mag > 255) mag = 255;
    if (256*ay <= TAN22*ax) sec = SEC_HORZ;
    else if (256*ay > TAN67*ax) sec = SEC_VERT;
    else if ((gx > 0) == (gy > 0)) sec = SEC_DIAG;
    else sec = SEC_ANTI;
    return {sec, mag[7:0]};
  endfunction

  function automatic bit [9:0] thin();
    bit [7:0] m, n1, n2;
    sector_t sec;
    m = win[1][4][7:0];
    sec = sector_t'(win[1][4][9:8]);
    case (sec)
      SEC_HORZ: begin n1 = win[1][3][7:0]; n2 = win[1][5][7:0]; end
      SEC_VERT: begin n1 = win[1][1][7:0]; n2 = win[1][7][7:0]; end
      SEC_DIAG: begin n1 = win[1][0][7:0]; n2 = win[1][8][7:0]; end
      default:  begin n1 = win[1][2][7:0]; n2 = win[1][6][7:0]; end
    endcase
    return (m < n1 || m < n2) ? 10'd0 : {2'b0, m};
  endfunction

  function automatic bit [7:0] hysteresis();
    int unsigned v;
    v = 32'(win[2][4]);
    if (v < lo_thr) return EDGE_OFF;
    if (v > hi_thr) return EDGE_ON;
    for (int i = 0; i < 9; i++)
      if (int'(win[2][i]) > int'(hi_thr)) return EDGE_ON;
    return EDGE_OFF;
  endfunction

  function automatic void restart_frame();
    pix_row = 0;
    pix_col = 0;
    drain_cnt = 0;
    draining = 0;
  endfunction

  function automatic void take_word(bit [7:0] pix, bit fl);
    int unsigned frame, s, a, b, c;
    edge_word_t e;
    frame = img_w * img_h;
    if (!draining && fl) return;  // flush inside a frame is dropped
    s = draining ? frame + drain_cnt : pix_row * img_w + pix_col;
    shift_in(0, s, draining ? 10'd0 : {2'b0, pix});
    if (s >= img_w + 1) begin
      a = s - img_w - 1;
      shift_in(1, a, is_interior(a) ? sobel() : 10'd0);
      if (a >= img_w + 1) begin
        b = a - img_w - 1;
        shift_in(2, b, is_interior(b) ? thin() : 10'd0);
        if (b >= img_w + 1) begin
          c = b - img_w - 1;
          if (c < frame) begin
            e.edge_v = is_interior(c) ? hysteresis() : EDGE_OFF;
            e.row = OUT_ROW_W'(c / img_w);
            e.col = OUT_COL_W'(c % img_w);
            e.last = (c == frame - 1);
            edge_q.push_back(e);
          end
        end
      end
    end
    if (!draining) begin
      pix_col++;
      if (pix_col >= img_w) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= img_h) begin
          pix_row = 0;
          draining = 1;
          drain_cnt = 0;
        end
      end
    end else if (drain_cnt >= 3*img_w + 2) begin
      restart_frame();
    end else begin
      drain_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    edge_word_t e;
    int unsigned v;
    if (!rst_n) begin
      hi_thr = 32'(HIGH_RST);
      lo_thr = 32'(LOW_RST);
      img_w  = 32'(WIDTH_RST);
      img_h  = 32'(HEIGHT_RST);
      for (int s = 0; s < 3; s++)
        for (int i = 0; i < 9; i++) win[s][i] = '0;
      restart_frame();
      edge_q.delete();
      fails <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HIGH: hi_thr = 32'(cfg_data[7:0]);
          REG_LOW:  lo_thr = 32'(cfg_data[7:0]);
          REG_WIDTH: begin
            v = 32'(cfg_data[IMG_W_W-1:0]);
            img_w = v < 3 ? 3 : (v > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : v);
            restart_frame();
          end
          default: begin
            v = 32'(cfg_data[IMG_H_W-1:0]);
            img_h = v < 3 ? 3 : (v > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : v);
            restart_frame();
          end
        endcase
      end
      if (in_valid && in_ready) take_word(in_pixel, in_flush);
      if (out_valid && out_ready) begin
        if (edge_q.size() == 0) begin
          $display("%0t: unexpected edge word: actual edge=%0d row=%0d col=%0d last=%0d",
                   $time, out_edge_res, out_row, out_col, out_frame_last);
          fails <= fails + 1;
        end else begin
          e = edge_q.pop_front();
          if (e.edge_v !== out_edge_res || e.row !== out_row || e.col !== out_col ||
              e.last !== out_frame_last) begin
            $display("%0t: edge word mismatch: expected edge=%0d row=%0d col=%0d last=%0d",
                     $time, e.edge_v, e.row, e.col, e.last);
            $display("%0t:                      actual edge=%0d row=%0d col=%0d last=%0d",
                     $time, out_edge_res, out_row, out_col, out_frame_last);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_canny_edge_detector.sv
// Top of the edge detector testbench: clock, reset, pixel stimulus and verdict.
module tb_canny_edge_detector;
  import ced_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 in_flush = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [PIX_W-1:0]     out_edge_res;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 out_frame_last;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fails, pending;
  int cycles = 0;
  int burst_left = 0;
  int rand_words = 0;
  int stall_mode = 0;
  int unsigned frame_w = 32'(WIDTH_RST), frame_h = 32'(HEIGHT_RST);

  always #6 clk = ~clk;

  canny_edge_detector DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel, .in_flush,
    .out_valid, .out_ready, .out_edge_res, .out_row, .out_col, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  canny_edge_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel, .in_flush,
    .out_valid, .out_ready, .out_edge_res, .out_row, .out_col, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_data, .fails, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("canny_edge_detector regression: fail");
      $finish;
    end
  end

  // receiver: out_ready follows a stall pattern that is chosen anew at random
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom % 4) != 0;
      2: out_ready <= (cycles % 16) < 5;
      default: out_ready <= ($urandom % 2) != 0;
    endcase
  end

  task automatic send_word(input logic [7:0] pix, input logic fl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom % 5 == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_flush <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    rand_words++;
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input int hi, input int lo, input int wv, input int hv);
    cfg_write(REG_HIGH, CFG_W'(hi));
    cfg_write(REG_LOW, CFG_W'(lo));
    cfg_write(REG_WIDTH, CFG_W'(wv));
    cfg_write(REG_HEIGHT, CFG_W'(hv));
    cfg_we <= 1'b0;
    @(posedge clk);
    frame_w = (wv & 'h7FF) < 3 ? 3 : ((wv & 'h7FF) > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : (wv & 'h7FF));
    frame_h = (hv & 'h1FFF) < 3 ? 3 :
              ((hv & 'h1FFF) > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : (hv & 'h1FFF));
  endtask

  function automatic logic [7:0] make_pixel(int style, int unsigned r, int unsigned c,
                                            int seed_a, int seed_b);
    int v;
    case (style)
      0: v = $urandom_range(0, 255);
      1: v = ($urandom % 2) ? 255 : 0;
      2: v = int'(c) * seed_a + int'(r) * seed_b + $urandom_range(0, 7);
      default: v = (int'(c) + int'(r) * (seed_b % 3 - 1) > seed_a % 8) ?
                   200 + $urandom_range(0, 55) : $urandom_range(0, 40);
    endcase
    return v[7:0];
  endfunction

  // one frame, cut short after stop_at pixels when stop_at > 0
  task automatic send_frame(input int stop_at);
    int style, sa, sb;
    style = $urandom_range(0, 3);
    sa = $urandom_range(0, 60);
    sb = $urandom_range(0, 60);
    for (int unsigned i = 0; i < frame_w * frame_h; i++) begin
      if (stop_at > 0 && i == stop_at) return;
      if ($urandom % 25 == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
      send_word(make_pixel(style, i / frame_w, i % frame_w, sa, sb), 1'b0);
    end
    for (int unsigned i = 0; i < 3 * frame_w + 3; i++)
      send_word(8'($urandom_range(0, 255)), ($urandom % 6) != 0);
  endtask

  initial begin
    int hi, lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 frame with a vertical step, flush inside the frame, pixel drain words
    set_config(100, 50, 3, 3);
    send_word(8'd0, 1'b0); send_word(8'd0, 1'b0); send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b0); send_word(8'd255, 1'b0); send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b0); send_word(8'd255, 1'b0); send_word(8'd255, 1'b0);
    for (int i = 0; i < 12; i++) send_word(8'hFF, i % 3 == 0 ? 1'b0 : 1'b1);
    drain_idle();

    for (int ph = 0; rand_words < 1200; ph++) begin
      case ($urandom % 7)
        0: begin hi = 0;   lo = 0;   end
        1: begin hi = 255; lo = 255; end
        2: begin hi = 255; lo = 0;   end
        3: begin hi = $urandom_range(0, 100); lo = $urandom_range(150, 255); end
        default: begin lo = $urandom_range(20, 150); hi = lo + $urandom_range(0, 105); end
      endcase
      if (ph % 9 == 4) set_config(hi, lo, $urandom_range(0, 2), $urandom_range(0, 2));
      else set_config(hi, lo, $urandom_range(3, 14), $urandom_range(3, 8));
      if (ph == 2) begin
        // abandon a frame half way, then restart with new geometry
        send_frame(int'(frame_w * frame_h / 2));
        drain_idle();
        set_config(hi, lo, $urandom_range(3, 14), $urandom_range(3, 8));
      end
      repeat ($urandom_range(1, 3)) send_frame(0);
      drain_idle();
    end

    // geometry limits, reached through clamping writes; frames are cut short
    set_config(180, 90, 2047, 3);
    send_frame(150);
    drain_idle();
    set_config(140, 60, 3, 8191);
    send_frame(300);
    drain_idle();

    if (fails == 0) begin
      $display("canny_edge_detector regression: pass");
    end else begin
      $display("canny_edge_detector regression: fail");
    end
    $finish;
  end

endmodule
